>>> src/urxrb_pkg.sv
// Shared types and constants for the UART receiver with receive ring.
package urxrb_pkg;

    // Default ring depth in bytes
    localparam int RING_DEPTH_DEF = 16;

    // Configuration port geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int TICK_W  = 16;

    // Register reset values
    localparam logic [TICK_W-1:0] BIT_TICKS_RST  = 16'd16;
    localparam logic [TICK_W-1:0] HALF_TICKS_RST = 16'd8;
    localparam logic [TICK_W-1:0] STOP_TICKS_RST = 16'd16;

    // Sampled data bit enters at the top of the shift byte
    localparam logic [7:0] MSB_MASK = 8'h80;

    // Register index on the configuration port (paddr[3:2])
    typedef enum logic [1:0] {
        REG_BIT_TICKS  = 2'd0,
        REG_HALF_TICKS = 2'd1,
        REG_STOP_TICKS = 2'd2
    } reg_idx_t;

    // Receiver phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_STOP  = 4'b1000
    } rx_phase_t;

    // Input beat
    typedef struct packed {
        logic req_type;
        logic rx_level;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [7:0] read_byte;
        logic       byte_available;
        logic       byte_stored;
        logic       read_empty;
    } rsp_t;

    // Timing registers
    typedef struct packed {
        logic [TICK_W-1:0] bit_ticks;
        logic [TICK_W-1:0] half_ticks;
        logic [TICK_W-1:0] stop_ticks;
    } cfg_t;

    // Store request from the frame receiver
    typedef struct packed {
        logic       stored;
        logic [7:0] data;
    } store_t;

endpackage

>>> src/urxrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module urxrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/urxrb_cfg.sv
// APB-style register block holding the receiver timing registers.
module urxrb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [urxrb_pkg::PADDR_W-1:0]  paddr,
    input  logic [urxrb_pkg::PDATA_W-1:0]  pwdata,
    output logic [urxrb_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output urxrb_pkg::cfg_t                cfg
);

    urxrb_pkg::cfg_t     cfg_reg;
    urxrb_pkg::cfg_t     cfg_next;
    urxrb_pkg::reg_idx_t idx;
    logic                wr_en;

    assign idx    = urxrb_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                urxrb_pkg::REG_BIT_TICKS:  cfg_next.bit_ticks  = pwdata[15:0];
                urxrb_pkg::REG_HALF_TICKS: cfg_next.half_ticks = pwdata[15:0];
                urxrb_pkg::REG_STOP_TICKS: cfg_next.stop_ticks = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_ticks  <= urxrb_pkg::BIT_TICKS_RST;
            cfg_reg.half_ticks <= urxrb_pkg::HALF_TICKS_RST;
            cfg_reg.stop_ticks <= urxrb_pkg::STOP_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            urxrb_pkg::REG_BIT_TICKS:  prdata = {16'd0, cfg_reg.bit_ticks};
            urxrb_pkg::REG_HALF_TICKS: prdata = {16'd0, cfg_reg.half_ticks};
            urxrb_pkg::REG_STOP_TICKS: prdata = {16'd0, cfg_reg.stop_ticks};
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> src/urxrb_frame.sv
// 8N1 frame receiver: start wait, eight data samples, stop wait, then store.
module urxrb_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                rx_level,
    input  urxrb_pkg::cfg_t     cfg,
    output urxrb_pkg::store_t   store
);

    urxrb_pkg::rx_phase_t                phase_reg, phase_next;
    logic [urxrb_pkg::TICK_W-1:0]        count_reg, count_next;
    logic [2:0]                          bit_reg, bit_next;
    logic [7:0]                          shift_reg, shift_next;
    logic [urxrb_pkg::TICK_W-1:0]        count_inc;
    logic [urxrb_pkg::TICK_W-1:0]        limit;
    logic [urxrb_pkg::TICK_W-1:0]        limit_eff;
    logic                                done;

    // Wait limit for the current phase; zero acts as one
    always_comb
    begin
        case (phase_reg)
            urxrb_pkg::PH_START: limit = cfg.half_ticks;
            urxrb_pkg::PH_DATA:  limit = cfg.bit_ticks;
            urxrb_pkg::PH_STOP:  limit = cfg.stop_ticks;
            default:             limit = cfg.bit_ticks;
        endcase
    end

    assign limit_eff = (limit == '0) ? {{(urxrb_pkg::TICK_W-1){1'b0}}, 1'b1} : limit;
    assign count_inc = count_reg + {{(urxrb_pkg::TICK_W-1){1'b0}}, 1'b1};
    assign done      = (count_inc >= limit_eff);

    // Phase sequencing for one tick
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        store      = '0;
        case (phase_reg)
            urxrb_pkg::PH_IDLE:
            begin
                if (!rx_level)
                begin
                    phase_next = urxrb_pkg::PH_START;
                    count_next = '0;
                    bit_next   = '0;
                end
            end
            urxrb_pkg::PH_START:
            begin
                count_next = done ? '0 : count_inc;
                if (done)
                begin
                    phase_next = urxrb_pkg::PH_DATA;
                end
            end
            urxrb_pkg::PH_DATA:
            begin
                count_next = done ? '0 : count_inc;
                if (done)
                begin
                    shift_next = (shift_reg >> 1) | (rx_level ? urxrb_pkg::MSB_MASK : 8'd0);
                    if (bit_reg == 3'd7)
                    begin
                        bit_next   = '0;
                        phase_next = urxrb_pkg::PH_STOP;
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            urxrb_pkg::PH_STOP:
            begin
                count_next = done ? '0 : count_inc;
                if (done)
                begin
                    store.stored = 1'b1;
                    store.data   = shift_reg;
                    phase_next   = urxrb_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = urxrb_pkg::PH_IDLE;
            end
        endcase
        if (!advance)
        begin
            store = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= urxrb_pkg::PH_IDLE;
            count_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

endmodule

>>> src/uart_rx_with_ring_buffer.sv
// Top level: UART 8N1 receiver feeding a receive ring held in RAM.
//
// Usage: every beat on the req channel is one oversampling tick of the
// receive line (rx_level) and may also ask to pop one byte (req_type = 1).
// Every req beat yields exactly one rsp beat carrying the popped byte (0 if
// none), whether bytes remain, whether a received byte was stored on that
// tick, and whether the pop found the ring empty.
// Each rsp beat follows in the cycle after its req beat; one beat per
// cycle. The ring lives in a RAM with registered read: the write and the
// read of a tick are issued on the accept edge and the read data appears in
// the output stage, with a bypass when the pop hits the byte being stored.
// When the rsp side stalls, the output stage holds and req_ready drops in
// the same cycle; no tick is taken until the held beat leaves.
// Reset clears the receiver to idle, both ring indices to zero and the
// timing registers to 16/8/16 ticks. Ring contents are not cleared; the
// index rules never read an entry that was not written.
// Timing registers sit on the APB-style port at byte offsets 0, 4 and 8.
module uart_rx_with_ring_buffer #(
    parameter int RING_DEPTH = urxrb_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  urxrb_pkg::req_t                req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output urxrb_pkg::rsp_t                rsp_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [urxrb_pkg::PADDR_W-1:0]  paddr,
    input  logic [urxrb_pkg::PDATA_W-1:0]  pwdata,
    output logic [urxrb_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    urxrb_pkg::cfg_t   cfg;
    urxrb_pkg::store_t store;
    logic              accept;

    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic              do_read;
    logic              empty_read;
    logic              fwd;
    logic [7:0]        ram_rdata;

    // Output stage
    logic              s1_valid_reg;
    logic              s1_read_reg;
    logic              s1_fwd_reg;
    logic [7:0]        s1_fwd_byte_reg;
    logic              s1_avail_reg;
    logic              s1_stored_reg;
    logic              s1_empty_reg;

    assign req_ready = !s1_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    urxrb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    urxrb_frame u_frame (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept),
        .rx_level (req_data.rx_level),
        .cfg      (cfg),
        .store    (store)
    );

    // Ring indices: store advances write first, then a pop checks emptiness
    always_comb
    begin
        widx_next = widx_reg;
        if (store.stored)
        begin
            widx_next = (widx_reg == IDX_LAST) ? '0 : widx_reg + IDX_W'(1);
        end
        do_read    = accept && req_data.req_type && (ridx_reg != widx_next);
        empty_read = req_data.req_type && (ridx_reg == widx_next);
        ridx_next  = ridx_reg;
        if (do_read)
        begin
            ridx_next = (ridx_reg == IDX_LAST) ? '0 : ridx_reg + IDX_W'(1);
        end
        fwd = store.stored && (ridx_next == widx_next);
    end

    urxrb_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (store.stored),
        .waddr (widx_next),
        .wdata (store.data),
        .re    (do_read),
        .raddr (ridx_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg     <= '0;
            ridx_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                widx_reg <= widx_next;
                ridx_reg <= ridx_next;
            end
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg     <= do_read;
            s1_fwd_reg      <= fwd;
            s1_fwd_byte_reg <= store.data;
            s1_avail_reg    <= (ridx_next != widx_next);
            s1_stored_reg   <= store.stored;
            s1_empty_reg    <= empty_read;
        end
    end

    assign rsp_valid                = s1_valid_reg;
    assign rsp_data.read_byte       = !s1_read_reg ? 8'd0 :
                                      (s1_fwd_reg ? s1_fwd_byte_reg : ram_rdata);
    assign rsp_data.byte_available  = s1_avail_reg;
    assign rsp_data.byte_stored     = s1_stored_reg;
    assign rsp_data.read_empty      = s1_empty_reg;

endmodule

>>> src/urxrb_checker.sv
// Port-level checks for the UART receiver with receive ring, bound to the top.
module urxrb_port_checks (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input urxrb_pkg::rsp_t rsp_data,
    input logic            pready
);

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("rsp beat changed while stalled");

    // Every accepted tick gives a result beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
    else $error("accepted tick produced no rsp beat");

    // An empty pop returns zero and leaves the ring empty
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.read_empty |->
            rsp_data.read_byte == 8'd0 && !rsp_data.byte_available)
    else $error("empty pop returned data or nonempty ring");

    // Input stalls only behind a waiting result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
    else $error("req_ready low with no stalled rsp beat");

    // Configuration port never waits
    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind uart_rx_with_ring_buffer urxrb_port_checks u_urxrb_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .pready    (pready)
);

>>> tb/sv/urxrb_checker.sv
// Checker for the UART receiver ring: mirrors the receiver per tick and compares result beats.
module urxrb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  urxrb_pkg::req_t               req_data,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  urxrb_pkg::rsp_t               rsp_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [urxrb_pkg::PADDR_W-1:0] paddr,
    input  logic [urxrb_pkg::PDATA_W-1:0] pwdata,
    input  logic [urxrb_pkg::PDATA_W-1:0] prdata,
    input  logic                          pready,
    output int                            fail_cnt,
    output int                            pending,
    output int                            checked
);
    import urxrb_pkg::*;

    // Depth is a power of two, so the pointers wrap by themselves
    localparam int PTR_W    = $clog2(RING_DEPTH_DEF);

    // Mirror of the receiver and of its timing registers
    cfg_t              cfg;
    rx_phase_t         rx_st;
    logic [TICK_W-1:0] tick_cnt;
    logic [2:0]        bit_idx;
    logic [7:0]        shifter;
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [7:0]        ring [RING_DEPTH_DEF];

    // Result beats owed by the block, oldest first
    rsp_t              due_results [$];

    initial
    begin
        fail_cnt = 0;
        pending  = 0;
        checked  = 0;
    end

    task automatic flag_mismatch(input string msg);
        fail_cnt++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // One oversampling tick: frame receiver first, then the pop
    task automatic step_receiver(input req_t beat, output rsp_t res);
        logic [TICK_W-1:0] lim;
        res = '0;
        if (rx_st == PH_IDLE)
        begin
            // low line while idle opens a frame
            if (!beat.rx_level)
            begin
                rx_st    = PH_START;
                tick_cnt = '0;
                bit_idx  = '0;
            end
        end
        else
        begin
            case (rx_st)
                PH_START: lim = cfg.half_ticks;
                PH_DATA:  lim = cfg.bit_ticks;
                default:  lim = cfg.stop_ticks;
            endcase
            // a zero delay behaves as one tick
            if (lim == '0)
            begin
                lim = TICK_W'(1);
            end
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= lim)
            begin
                tick_cnt = '0;
                case (rx_st)
                    PH_START:
                    begin
                        rx_st = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        // LSB first: new sample enters at the top
                        shifter = {beat.rx_level, shifter[7:1]};
                        if (bit_idx == 3'd7)
                        begin
                            bit_idx = '0;
                            rx_st   = PH_STOP;
                        end
                        else
                        begin
                            bit_idx = bit_idx + 3'd1;
                        end
                    end
                    default:
                    begin
                        // stop bit is not checked; overrun simply wraps
                        wr_ptr           = wr_ptr + 1'b1;
                        ring[wr_ptr]     = shifter;
                        res.byte_stored  = 1'b1;
                        rx_st            = PH_IDLE;
                    end
                endcase
            end
        end

        // pop sees a byte stored on this same tick
        if (beat.req_type)
        begin
            if (rd_ptr == wr_ptr)
            begin
                res.read_empty = 1'b1;
            end
            else
            begin
                rd_ptr        = rd_ptr + 1'b1;
                res.read_byte = ring[rd_ptr];
            end
        end
        res.byte_available = (rd_ptr != wr_ptr);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t              want;
        rsp_t              res;
        logic [TICK_W-1:0] reg_want;
        logic              reg_known;
        if (!rst_n)
        begin
            cfg.bit_ticks  = BIT_TICKS_RST;
            cfg.half_ticks = HALF_TICKS_RST;
            cfg.stop_ticks = STOP_TICKS_RST;
            rx_st          = PH_IDLE;
            tick_cnt       = '0;
            bit_idx        = '0;
            shifter        = '0;
            wr_ptr         = '0;
            rd_ptr         = '0;
            due_results.delete();
            pending       <= 0;
        end
        else
        begin
            // Result beat against the oldest owed one
            if (rsp_valid && rsp_ready)
            begin
                if (due_results.size() == 0)
                begin
                    flag_mismatch("result beat with nothing due");
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp_data.read_byte !== want.read_byte)
                    begin
                        flag_mismatch($sformatf("beat %0d read_byte got %h want %h",
                            checked, rsp_data.read_byte, want.read_byte));
                    end
                    if (rsp_data.byte_available !== want.byte_available)
                    begin
                        flag_mismatch($sformatf("beat %0d byte_available got %b want %b",
                            checked, rsp_data.byte_available, want.byte_available));
                    end
                    if (rsp_data.byte_stored !== want.byte_stored)
                    begin
                        flag_mismatch($sformatf("beat %0d byte_stored got %b want %b",
                            checked, rsp_data.byte_stored, want.byte_stored));
                    end
                    if (rsp_data.read_empty !== want.read_empty)
                    begin
                        flag_mismatch($sformatf("beat %0d read_empty got %b want %b",
                            checked, rsp_data.read_empty, want.read_empty));
                    end
                    checked++;
                end
            end

            // Register write takes effect at the access edge
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_BIT_TICKS:  cfg.bit_ticks  = pwdata[TICK_W-1:0];
                    REG_HALF_TICKS: cfg.half_ticks = pwdata[TICK_W-1:0];
                    REG_STOP_TICKS: cfg.stop_ticks = pwdata[TICK_W-1:0];
                    default: ;
                endcase
            end

            // Register read-back, zero extended
            if (psel && penable && !pwrite && pready)
            begin
                reg_known = 1'b1;
                reg_want  = '0;
                case (reg_idx_t'(paddr[3:2]))
                    REG_BIT_TICKS:  reg_want = cfg.bit_ticks;
                    REG_HALF_TICKS: reg_want = cfg.half_ticks;
                    REG_STOP_TICKS: reg_want = cfg.stop_ticks;
                    default:        reg_known = 1'b0;
                endcase
                if (reg_known && prdata !== {{(PDATA_W-TICK_W){1'b0}}, reg_want})
                begin
                    flag_mismatch($sformatf("register at %h read %h want %h",
                        paddr, prdata, reg_want));
                end
            end

            // Accepted tick: work out its result
            if (req_valid && req_ready)
            begin
                step_receiver(req_data, res);
                due_results.push_back(res);
            end

            pending <= due_results.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top: drives receive-line ticks, pops and register traffic, then gives the verdict.
module tb_top;
    import urxrb_pkg::*;

    localparam int RAND_TICKS  = 1200;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 400000;
    // Unused register slot: writes there must change nothing
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [TICK_W-1:0] TICKS_MAX = 16'hFFFF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req_data  = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_cnt;
    int pending;
    int checked;

    // Stimulus bookkeeping and knobs
    int   cycle_cnt  = 0;
    int   n_items    = 0;
    int   n_frames   = 0;
    int   n_pops     = 0;
    int   n_writes   = 0;
    int   pop_pct    = 0;
    int   quiet_from = 32'h7fffffff;
    bit   gaps_on    = 1'b0;
    bit   stall_on   = 1'b0;
    cfg_t cur        = '{bit_ticks: BIT_TICKS_RST, half_ticks: HALF_TICKS_RST,
                         stop_ticks: STOP_TICKS_RST};

    uart_rx_with_ring_buffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    urxrb_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fail_cnt  (fail_cnt),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Run limit
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: ready drops in random bursts, steady in the tail
    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (stall_on && n_items < quiet_from && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 6);
                rsp_ready <= 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 12);
                rsp_ready <= 1'b1;
            end
            repeat (n) @(posedge clk);
        end
    end

    function automatic int eff_ticks(input logic [TICK_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic logic want_pop();
        return $urandom_range(0, 99) < pop_pct;
    endfunction

    // One tick beat; valid stays up until the next call or a gap
    task automatic put_tick(input logic pop, input logic lvl);
        req_t beat;
        beat.req_type = pop;
        beat.rx_level = lvl;
        if (gaps_on && n_items < quiet_from && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        do
            @(posedge clk);
        while (!req_ready);
        n_items++;
        if (pop)
        begin
            n_pops++;
        end
    endtask

    // Stop sending and wait until every owed result beat has left
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [TICK_W-1:0] val);
        logic [PDATA_W-TICK_W-1:0] junk;
        settle();
        junk = (PDATA_W-TICK_W)'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BIT_TICKS:  cur.bit_ticks  = val;
            REG_HALF_TICKS: cur.half_ticks = val;
            REG_STOP_TICKS: cur.stop_ticks = val;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic reg_read(input logic [1:0] idx);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Well-formed 8N1 frame at the current timing; each bit ends on its sample tick
    task automatic send_frame(input logic [7:0] data, input bit pop_last);
        int h;
        int b;
        int s;
        int k;
        h = eff_ticks(cur.half_ticks);
        b = eff_ticks(cur.bit_ticks);
        s = eff_ticks(cur.stop_ticks);
        put_tick(want_pop(), 1'b0);
        repeat (h) put_tick(want_pop(), 1'b0);
        for (k = 0; k < 8; k++)
        begin
            repeat (b) put_tick(want_pop(), data[k]);
        end
        repeat (s - 1) put_tick(want_pop(), 1'b1);
        // last stop tick is the store tick
        put_tick(pop_last | want_pop(), 1'b1);
        n_frames++;
    endtask

    // Random line levels, then enough high ticks for any frame to finish
    task automatic line_noise();
        int span;
        span = eff_ticks(cur.half_ticks) + 8 * eff_ticks(cur.bit_ticks)
               + eff_ticks(cur.stop_ticks) + 1;
        repeat ($urandom_range(1, 8)) put_tick(want_pop(), 1'($urandom_range(0, 1)));
        repeat (span) put_tick(want_pop(), 1'b1);
    endtask

    // Park the receiver in a 65535-tick wait, then cut the limit below the count
    task automatic long_wait(input logic [1:0] which);
        int k;
        pop_pct  = 20;
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        reg_write(REG_BIT_TICKS, 16'd1);
        reg_write(REG_HALF_TICKS, 16'd1);
        reg_write(REG_STOP_TICKS, 16'd1);
        reg_write(which, TICKS_MAX);
        reg_read(which);
        put_tick(want_pop(), 1'b0);
        if (which != REG_HALF_TICKS)
        begin
            put_tick(want_pop(), 1'b0);
        end
        if (which == REG_STOP_TICKS)
        begin
            for (k = 0; k < 8; k++)
            begin
                put_tick(want_pop(), 1'($urandom_range(0, 1)));
            end
        end
        repeat (40) put_tick(want_pop(), 1'($urandom_range(0, 1)));
        // count is already past the new limit: the wait ends on the next tick
        reg_write(which, 16'd1);
        repeat (12) put_tick(want_pop(), 1'b1);
    endtask

    // Random timing, pop rate and idling, then a run of frames and noise
    task automatic run_segment(input bit overrun);
        int                mode;
        int                frames;
        int                k;
        logic [TICK_W-1:0] bt;
        logic [TICK_W-1:0] ht;
        logic [TICK_W-1:0] st;
        mode = $urandom_range(0, 9);
        if (mode == 0 && !overrun)
        begin
            bt     = BIT_TICKS_RST;
            ht     = HALF_TICKS_RST;
            st     = STOP_TICKS_RST;
            frames = 2;
        end
        else if (mode == 1)
        begin
            bt     = '0;
            ht     = '0;
            st     = '0;
            frames = $urandom_range(3, 12);
        end
        else
        begin
            bt     = TICK_W'($urandom_range(1, 5));
            ht     = TICK_W'($urandom_range(0, 3));
            st     = TICK_W'($urandom_range(0, 4));
            frames = $urandom_range(3, 12);
        end
        if (overrun)
        begin
            frames = 20;
        end
        reg_write(REG_BIT_TICKS, bt);
        reg_write(REG_HALF_TICKS, ht);
        reg_write(REG_STOP_TICKS, st);
        case ($urandom_range(0, 3))
            0:       pop_pct = 3;
            1:       pop_pct = 15;
            2:       pop_pct = 40;
            default: pop_pct = 80;
        endcase
        if (overrun)
        begin
            // no pops: the ring fills and wraps over unread bytes
            pop_pct = 0;
        end
        gaps_on  = $urandom_range(0, 2) != 0;
        stall_on = $urandom_range(0, 2) != 0;
        for (k = 0; k < frames; k++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                line_noise();
            end
            else
            begin
                send_frame(8'($urandom_range(0, 255)), 1'b0);
            end
            repeat ($urandom_range(0, 3)) put_tick(want_pop(), 1'b1);
        end
    endtask

    initial
    begin
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of the timing registers
        reg_read(REG_BIT_TICKS);
        reg_read(REG_HALF_TICKS);
        reg_read(REG_STOP_TICKS);

        // Directed: zero delays act as one tick, empty pop, pop on the store tick
        reg_write(REG_BIT_TICKS, '0);
        reg_write(REG_HALF_TICKS, '0);
        reg_write(REG_STOP_TICKS, '0);
        pop_pct  = 0;
        stall_on = 1'b1;
        put_tick(1'b1, 1'b1);
        send_frame(8'hA5, 1'b1);
        put_tick(1'b1, 1'b1);
        send_frame(8'hFF, 1'b0);
        put_tick(1'b1, 1'b1);
        put_tick(1'b1, 1'b0);

        // Largest delays, cut short mid-frame
        long_wait(REG_HALF_TICKS);
        long_wait(REG_BIT_TICKS);
        long_wait(REG_STOP_TICKS);
        reg_write(REG_SPARE, 16'h0003);
        reg_read(REG_BIT_TICKS);
        reg_read(REG_HALF_TICKS);
        reg_read(REG_STOP_TICKS);

        // Random part; the tail runs with no idling on either side
        target     = n_items + RAND_TICKS;
        quiet_from = target - QUIET_TAIL;
        run_segment(1'b1);
        while (n_items < target)
        begin
            run_segment(1'b0);
        end

        settle();
        repeat (4) @(posedge clk);

        $display("Sent %0d line ticks (%0d with a pop) carrying %0d frames, %0d register writes.",
            n_items, n_pops, n_frames, n_writes);
        $display("Compared %0d result beats, %0d mismatches.", checked, fail_cnt);
        if (fail_cnt == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
